@@ rtl/eos_pkg.sv @@
`timescale 1ns / 1ps

package eos_pkg;

    // Width of the encoder codes that take part in the mapping.
    localparam int CODE_BITS = 16;

    // Width of the opening, offset and travel values.
    localparam int VAL_BITS = 16;

    // Width of the per-mille result.
    localparam int PM_BITS = 10;

    // Distance times travel, and the first divider's working word.
    localparam int PROD_BITS = CODE_BITS + VAL_BITS;

    // Opening difference times 1000, and the second divider's working word.
    localparam int WORK2_BITS = VAL_BITS + PM_BITS;

    // Configuration port geometry.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // Largest opening reported; the all-ones code is kept for faults.
    localparam logic [VAL_BITS-1:0] OPENING_MAX = 16'd65534;

    // Full scale of the per-mille result.
    localparam logic [PM_BITS-1:0] PER_MILLE_FULL = 10'd1000;

    // Reset value of the open calibration code.
    localparam logic [VAL_BITS-1:0] CODE_OPEN_RESET = 16'hFFFF;

    // Register indexes on the configuration port (word address).
    typedef enum logic [1:0] {
        REG_POSITION_OFFSET = 2'd0,
        REG_FULL_TRAVEL     = 2'd1,
        REG_CODE_AT_CLOSED  = 2'd2,
        REG_CODE_AT_OPEN    = 2'd3
    } reg_idx_t;

endpackage

@@ rtl/encoder_opening_scaler.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// input     in_valid, in_ready, raw_code              sample in
// output    out_valid, out_ready, opening, per_mille  result out
// config    psel, penable, pwrite, paddr, pwdata,     APB-style, 4 registers
//           prdata, pready
//
// One sample is taken per cycle while in_ready is high, that is while the skid
// register is empty. The two restoring dividers take 16 stages for the scaling
// and 10 for the per-mille figure.
// Reset clears all valid bits and loads the calibration registers.
// A stall of the output parks one result in a skid register and freezes the
// whole pipeline on the next cycle; nothing is lost or repeated.
module encoder_opening_scaler
    import eos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VAL_BITS-1:0]   raw_code,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VAL_BITS-1:0]   opening,
    output logic [PM_BITS-1:0]    per_mille,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    localparam int DIV1_STEPS = VAL_BITS;
    localparam int DIV2_STEPS = PM_BITS;

    // Calibration registers.
    logic [VAL_BITS-1:0] position_offset_reg;
    logic [VAL_BITS-1:0] full_travel_reg;
    logic [VAL_BITS-1:0] code_at_closed_reg;
    logic [VAL_BITS-1:0] code_at_open_reg;

    reg_idx_t cfg_idx;
    logic     cfg_write;

    // Pipeline advance, held off while the skid register is full.
    logic adv;

    // Stage A: input sample.
    logic                 a_valid_reg;
    logic [CODE_BITS-1:0] a_raw_reg;

    // Stage B: span and raw distance.
    logic                 b_valid_reg;
    logic [CODE_BITS-1:0] b_span_reg;
    logic [CODE_BITS-1:0] b_dist_reg;
    logic [CODE_BITS-1:0] b_span_next;
    logic [CODE_BITS-1:0] b_dist_next;
    logic [CODE_BITS-1:0] cal_lo;
    logic [CODE_BITS-1:0] cal_hi;

    // Stage C: distance clamped to the span.
    logic                 c_valid_reg;
    logic [CODE_BITS-1:0] c_span_reg;
    logic [CODE_BITS-1:0] c_dist_reg;

    // Stages E0..E16: product, then one quotient bit per stage.
    logic                 e_valid_reg [0:DIV1_STEPS];
    logic [PROD_BITS-1:0] e_work_reg  [0:DIV1_STEPS];
    logic [CODE_BITS-1:0] e_span_reg  [0:DIV1_STEPS];

    // Stage F: saturated opening.
    logic                 f_valid_reg;
    logic [VAL_BITS-1:0]  f_opening_reg;
    logic [VAL_BITS-1:0]  f_opening_next;
    logic [VAL_BITS:0]    f_sum;

    // Stage G: difference above offset and the per-mille guard.
    logic                 g_valid_reg;
    logic [VAL_BITS-1:0]  g_opening_reg;
    logic [VAL_BITS-1:0]  g_diff_reg;
    logic                 g_guard_reg;

    // Stages I0..I10: scaled difference, then one quotient bit per stage.
    logic                  i_valid_reg   [0:DIV2_STEPS];
    logic [WORK2_BITS-1:0] i_work_reg    [0:DIV2_STEPS];
    logic [VAL_BITS-1:0]   i_opening_reg [0:DIV2_STEPS];
    logic                  i_guard_reg   [0:DIV2_STEPS];

    // Tail result ahead of the output register.
    logic [PM_BITS-1:0]  tail_q;
    logic [PM_BITS-1:0]  tail_pm;
    logic                tail_valid;

    // Output register and skid register.
    logic                out_valid_reg;
    logic [VAL_BITS-1:0] out_opening_reg;
    logic [PM_BITS-1:0]  out_pm_reg;
    logic                skid_valid_reg;
    logic [VAL_BITS-1:0] skid_opening_reg;
    logic [PM_BITS-1:0]  skid_pm_reg;
    logic                out_load;

    // Configuration port: writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_offset_reg <= '0;
            full_travel_reg     <= '0;
            code_at_closed_reg  <= '0;
            code_at_open_reg    <= CODE_OPEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_POSITION_OFFSET: position_offset_reg <= pwdata[VAL_BITS-1:0];
                REG_FULL_TRAVEL:     full_travel_reg     <= pwdata[VAL_BITS-1:0];
                REG_CODE_AT_CLOSED:  code_at_closed_reg  <= pwdata[VAL_BITS-1:0];
                REG_CODE_AT_OPEN:    code_at_open_reg    <= pwdata[VAL_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            REG_POSITION_OFFSET: prdata = DATA_BITS'(position_offset_reg);
            REG_FULL_TRAVEL:     prdata = DATA_BITS'(full_travel_reg);
            REG_CODE_AT_CLOSED:  prdata = DATA_BITS'(code_at_closed_reg);
            REG_CODE_AT_OPEN:    prdata = DATA_BITS'(code_at_open_reg);
            default:             prdata = '0;
        endcase
    end

    assign adv      = ~skid_valid_reg;
    assign in_ready = adv;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            e_valid_reg[0] <= c_valid_reg;
        end
    end

    // Direction, span and distance from the closed code.
    assign cal_lo = code_at_closed_reg[CODE_BITS-1:0];
    assign cal_hi = code_at_open_reg[CODE_BITS-1:0];

    always_comb
    begin
        if (cal_hi > cal_lo)
        begin
            b_span_next = cal_hi - cal_lo;
            b_dist_next = (a_raw_reg > cal_lo) ? (a_raw_reg - cal_lo) : '0;
        end
        else
        begin
            b_span_next = cal_lo - cal_hi;
            b_dist_next = (a_raw_reg < cal_lo) ? (cal_lo - a_raw_reg) : '0;
        end
    end

    // Front stage payload: sample, distance, clamp, product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_raw_reg     <= raw_code[CODE_BITS-1:0];
            b_span_reg    <= b_span_next;
            b_dist_reg    <= b_dist_next;
            c_span_reg    <= b_span_reg;
            c_dist_reg    <= (b_dist_reg > b_span_reg) ? b_span_reg : b_dist_reg;
            e_span_reg[0] <= c_span_reg;
            e_work_reg[0] <= PROD_BITS'(c_dist_reg) * PROD_BITS'(full_travel_reg);
        end
    end

    // Scaling divider: product over span, one quotient bit per stage.
    // The quotient never exceeds the travel, so the upper product half
    // already is the starting remainder.
    for (genvar k = 1; k <= DIV1_STEPS; k++)
    begin : g_div1
        logic [CODE_BITS:0]   trial;
        logic [CODE_BITS:0]   dvs;
        logic                 fits;
        logic [CODE_BITS:0]   rem_sub;
        logic [PROD_BITS-1:0] work_next;

        always_comb
        begin
            trial   = {e_work_reg[k-1][PROD_BITS-1 -: CODE_BITS],
                       e_work_reg[k-1][VAL_BITS-1]};
            dvs     = {1'b0, e_span_reg[k-1]};
            fits    = (trial >= dvs);
            rem_sub = fits ? (trial - dvs) : trial;
            work_next = {rem_sub[CODE_BITS-1:0],
                         e_work_reg[k-1][VAL_BITS-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                e_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                e_valid_reg[k] <= e_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                e_work_reg[k] <= work_next;
                e_span_reg[k] <= e_span_reg[k-1];
            end
        end
    end

    // Offset added, zero span passes the offset alone, then saturation.
    always_comb
    begin
        if (e_span_reg[DIV1_STEPS] == '0)
        begin
            f_sum = {1'b0, position_offset_reg};
        end
        else
        begin
            f_sum = {1'b0, position_offset_reg}
                  + {1'b0, e_work_reg[DIV1_STEPS][VAL_BITS-1:0]};
        end
        f_opening_next = (f_sum > {1'b0, OPENING_MAX}) ? OPENING_MAX
                                                       : f_sum[VAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg    <= 1'b0;
            g_valid_reg    <= 1'b0;
            i_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg    <= e_valid_reg[DIV1_STEPS];
            g_valid_reg    <= f_valid_reg;
            i_valid_reg[0] <= g_valid_reg;
        end
    end

    // Opening, per-mille guard and scaled difference.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_opening_reg    <= f_opening_next;
            g_opening_reg    <= f_opening_reg;
            g_diff_reg       <= f_opening_reg - position_offset_reg;
            g_guard_reg      <= (f_opening_reg <= position_offset_reg)
                              || (full_travel_reg == '0);
            i_work_reg[0]    <= WORK2_BITS'(g_diff_reg) * WORK2_BITS'(PER_MILLE_FULL);
            i_opening_reg[0] <= g_opening_reg;
            i_guard_reg[0]   <= g_guard_reg;
        end
    end

    // Per-mille divider: scaled difference over travel. The difference
    // never exceeds the travel, so the quotient fits the result width.
    for (genvar k = 1; k <= DIV2_STEPS; k++)
    begin : g_div2
        logic [VAL_BITS:0]     trial;
        logic [VAL_BITS:0]     dvs;
        logic                  fits;
        logic [VAL_BITS:0]     rem_sub;
        logic [WORK2_BITS-1:0] work_next;

        always_comb
        begin
            trial   = {i_work_reg[k-1][WORK2_BITS-1 -: VAL_BITS],
                       i_work_reg[k-1][PM_BITS-1]};
            dvs     = {1'b0, full_travel_reg};
            fits    = (trial >= dvs);
            rem_sub = fits ? (trial - dvs) : trial;
            work_next = {rem_sub[VAL_BITS-1:0],
                         i_work_reg[k-1][PM_BITS-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                i_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                i_valid_reg[k] <= i_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                i_work_reg[k]    <= work_next;
                i_opening_reg[k] <= i_opening_reg[k-1];
                i_guard_reg[k]   <= i_guard_reg[k-1];
            end
        end
    end

    // Guarded and capped per-mille result at the pipeline tail.
    assign tail_valid = i_valid_reg[DIV2_STEPS];
    assign tail_q     = i_work_reg[DIV2_STEPS][PM_BITS-1:0];

    always_comb
    begin
        if (i_guard_reg[DIV2_STEPS])
        begin
            tail_pm = '0;
        end
        else if (tail_q > PER_MILLE_FULL)
        begin
            tail_pm = PER_MILLE_FULL;
        end
        else
        begin
            tail_pm = tail_q;
        end
    end

    // Output register with a skid register behind it.
    assign out_load = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= skid_valid_reg | tail_valid;
            end
            if (out_load)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (adv && tail_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_opening_reg <= skid_valid_reg ? skid_opening_reg
                                              : i_opening_reg[DIV2_STEPS];
            out_pm_reg      <= skid_valid_reg ? skid_pm_reg : tail_pm;
        end
        if (!out_load && adv)
        begin
            skid_opening_reg <= i_opening_reg[DIV2_STEPS];
            skid_pm_reg      <= tail_pm;
        end
    end

    assign out_valid = out_valid_reg;
    assign opening   = out_opening_reg;
    assign per_mille = out_pm_reg;

endmodule
